FILE: hdl/skt_pkg.sv
// Shared types, codes and defaults for the sorted keyed table.
package skt_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;
	localparam int COUNT_PORT_W   = 11;

	localparam logic [3:0] OP_INSERT = 4'd0;
	localparam logic [3:0] OP_GET    = 4'd1;
	localparam logic [3:0] OP_FIRST  = 4'd2;
	localparam logic [3:0] OP_LAST   = 4'd3;
	localparam logic [3:0] OP_NEXT   = 4'd4;
	localparam logic [3:0] OP_PREV   = 4'd5;
	localparam logic [3:0] OP_UPDATE = 4'd6;
	localparam logic [3:0] OP_DELETE = 4'd7;
	localparam logic [3:0] OP_RESET  = 4'd8;
	localparam logic [3:0] OP_COUNT  = 4'd9;

	localparam logic [3:0] ST_NONE     = 4'd0;
	localparam logic [3:0] ST_DUP      = 4'd1;
	localparam logic [3:0] ST_NOTFOUND = 4'd2;
	localparam logic [3:0] ST_EMPTY    = 4'd3;
	localparam logic [3:0] ST_TAIL     = 4'd4;
	localparam logic [3:0] ST_HEAD     = 4'd5;
	localparam logic [3:0] ST_BADUPD   = 4'd6;
	localparam logic [3:0] ST_BADDEL   = 4'd7;
	localparam logic [3:0] ST_FULL     = 4'd8;

	typedef enum logic [2:0] {
		RA_ZERO, RA_INC, RA_DEC, RA_LAST, RA_CUR, RA_CUR_INC, RA_CUR_DEC
	} rd_addr_t;

	typedef enum logic [2:0] {
		WR_NONE, WR_SHIFT_UP, WR_SHIFT_DN, WR_NEW, WR_VALUE
	} wr_sel_t;

	typedef enum logic [1:0] {POS_KEEP, POS_IDX, POS_COUNT} pos_sel_t;

	typedef enum logic [1:0] {CNT_KEEP, CNT_INC, CNT_DEC, CNT_CLR} cnt_op_t;

	typedef enum logic [1:0] {CUR_KEEP, CUR_CLR, CUR_SET} cur_op_t;

	typedef struct packed {
		logic       load;
		logic       rd_en;
		rd_addr_t   ra_sel;
		wr_sel_t    wr_sel;
		pos_sel_t   pos_sel;
		cnt_op_t    cnt_op;
		cur_op_t    cur_op;
		logic       res_set;
		logic       res_ok;
		logic [3:0] res_status;
		logic       res_data;
		logic       res_cnt_start;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic [3:0] op;
		logic       cnt_zero;
		logic       cnt_full;
		logic       cur_valid;
		logic       cur_first;
		logic       cur_last;
		logic       cmp_eq;
		logic       cmp_lt;
		logic       idx_last;
		logic       idx_at_pos;
		logic       pos_at_end;
	} sts_t;

endpackage

FILE: hdl/skt_datapath.sv
// Datapath of the sorted keyed table: entry memories, cursor, counters and result registers.
module skt_datapath #(
	parameter int CAPACITY   = skt_pkg::CAPACITY_DEF,
	parameter int KEY_BITS   = skt_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = skt_pkg::VALUE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  skt_pkg::cmd_t                    cmd,
	output skt_pkg::sts_t                    sts,
	input  logic                             cfg_valid,
	input  logic                             cfg_data,
	input  logic [3:0]                       op,
	input  logic [KEY_BITS-1:0]              key,
	input  logic [VALUE_BITS-1:0]            value,
	output logic                             ok,
	output logic [3:0]                       status,
	output logic [KEY_BITS-1:0]              found_key,
	output logic [VALUE_BITS-1:0]            found_value,
	output logic [skt_pkg::COUNT_PORT_W-1:0] entry_count
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [KEY_BITS-1:0]   key_mem [CAPACITY];
	logic [VALUE_BITS-1:0] val_mem [CAPACITY];

	logic [3:0]            op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [KEY_BITS-1:0]   rd_key_q;
	logic [VALUE_BITS-1:0] rd_val_q;
	logic [AW-1:0]         idx_q;
	logic [CW-1:0]         pos_q;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         cur_q;
	logic                  cur_valid_q;
	logic                  signed_q;

	logic                  res_ok_q;
	logic [3:0]            res_status_q;
	logic                  res_data_q;
	logic                  res_keep_q;
	logic [CW-1:0]         res_cnt_q;

	logic [AW-1:0]         ra;
	logic [AW-1:0]         wa;
	logic                  key_we;
	logic                  val_we;
	logic [KEY_BITS-1:0]   wk;
	logic [VALUE_BITS-1:0] wv;
	logic [KEY_BITS-1:0]   flip;

	always_comb begin
		case (cmd.ra_sel)
			skt_pkg::RA_ZERO:    ra = '0;
			skt_pkg::RA_INC:     ra = idx_q + AW'(1);
			skt_pkg::RA_DEC:     ra = idx_q - AW'(1);
			skt_pkg::RA_LAST:    ra = AW'(count_q - CW'(1));
			skt_pkg::RA_CUR:     ra = cur_q;
			skt_pkg::RA_CUR_INC: ra = cur_q + AW'(1);
			skt_pkg::RA_CUR_DEC: ra = cur_q - AW'(1);
			default:             ra = '0;
		endcase
	end

	always_comb begin
		wa     = idx_q;
		wk     = rd_key_q;
		wv     = rd_val_q;
		key_we = 1'b0;
		val_we = 1'b0;
		case (cmd.wr_sel)
			skt_pkg::WR_SHIFT_UP: begin
				wa     = idx_q + AW'(1);
				key_we = 1'b1;
				val_we = 1'b1;
			end
			skt_pkg::WR_SHIFT_DN: begin
				wa     = idx_q - AW'(1);
				key_we = 1'b1;
				val_we = 1'b1;
			end
			skt_pkg::WR_NEW: begin
				wa     = AW'(pos_q);
				wk     = key_q;
				wv     = value_q;
				key_we = 1'b1;
				val_we = 1'b1;
			end
			skt_pkg::WR_VALUE: begin
				wa     = cur_q;
				wv     = value_q;
				val_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[wa] <= wk;
		end
		if (val_we) begin
			val_mem[wa] <= wv;
		end
		if (cmd.rd_en) begin
			rd_key_q <= key_mem[ra];
			rd_val_q <= val_mem[ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op;
			key_q   <= key;
			value_q <= value;
		end
		if (cmd.rd_en) begin
			idx_q <= ra;
		end
		case (cmd.pos_sel)
			skt_pkg::POS_IDX:   pos_q <= CW'(idx_q);
			skt_pkg::POS_COUNT: pos_q <= count_q;
			default:            pos_q <= pos_q;
		endcase
		if (cmd.res_set) begin
			res_ok_q     <= cmd.res_ok;
			res_status_q <= cmd.res_status;
			res_data_q   <= cmd.res_data;
			res_keep_q   <= cmd.res_cnt_start;
			res_cnt_q    <= count_q;
		end
		if (cmd.out_load) begin
			ok          <= res_ok_q;
			status      <= res_status_q;
			found_key   <= res_data_q ? rd_key_q : '0;
			found_value <= res_data_q ? rd_val_q : '0;
			entry_count <= skt_pkg::COUNT_PORT_W'(res_keep_q ? res_cnt_q : count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cur_q       <= '0;
			cur_valid_q <= 1'b0;
			signed_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				signed_q <= cfg_data;
			end
			case (cmd.cnt_op)
				skt_pkg::CNT_INC: count_q <= count_q + CW'(1);
				skt_pkg::CNT_DEC: count_q <= count_q - CW'(1);
				skt_pkg::CNT_CLR: count_q <= '0;
				default:          count_q <= count_q;
			endcase
			case (cmd.cur_op)
				skt_pkg::CUR_CLR: cur_valid_q <= 1'b0;
				skt_pkg::CUR_SET: begin
					cur_q       <= idx_q;
					cur_valid_q <= 1'b1;
				end
				default: cur_valid_q <= cur_valid_q;
			endcase
		end
	end

	assign flip = {signed_q, {(KEY_BITS - 1){1'b0}}};

	always_comb begin
		sts.op         = op_q;
		sts.cnt_zero   = (count_q == '0);
		sts.cnt_full   = (count_q == CW'(CAPACITY));
		sts.cur_valid  = cur_valid_q;
		sts.cur_first  = (cur_q == '0);
		sts.cur_last   = ((CW'(cur_q) + CW'(1)) >= count_q);
		sts.cmp_eq     = (key_q == rd_key_q);
		sts.cmp_lt     = ((key_q ^ flip) < (rd_key_q ^ flip));
		sts.idx_last   = ((CW'(idx_q) + CW'(1)) == count_q);
		sts.idx_at_pos = (CW'(idx_q) == pos_q);
		sts.pos_at_end = (pos_q == count_q);
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count exceeds capacity");
	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (CW'(cur_q) < count_q))
		else $error("cursor marks an entry beyond the count");
	a_place_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_sel == skt_pkg::WR_NEW) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("new entry written without count increment");
`endif

endmodule

FILE: hdl/skt_ctrl.sv
// Controller state machine of the sorted keyed table.
module skt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  skt_pkg::sts_t sts,
	output skt_pkg::cmd_t cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_SCAN_INS, S_INS_CHK, S_SHIFT_UP, S_PLACE,
		S_SCAN_GET, S_READ_SET, S_CHECK, S_SHIFT_DN, S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_DONE;
				cmd.res_set = 1'b1;
				case (sts.op)
					skt_pkg::OP_INSERT: begin
						cmd.cur_op  = skt_pkg::CUR_CLR;
						cmd.res_set = 1'b0;
						if (sts.cnt_zero) begin
							cmd.pos_sel = skt_pkg::POS_COUNT;
							state_d     = S_PLACE;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.ra_sel = skt_pkg::RA_ZERO;
							state_d    = S_SCAN_INS;
						end
					end
					skt_pkg::OP_GET: begin
						cmd.cur_op = skt_pkg::CUR_CLR;
						if (sts.cnt_zero) begin
							cmd.res_status = skt_pkg::ST_NOTFOUND;
						end else begin
							cmd.res_set = 1'b0;
							cmd.rd_en   = 1'b1;
							cmd.ra_sel  = skt_pkg::RA_ZERO;
							state_d     = S_SCAN_GET;
						end
					end
					skt_pkg::OP_FIRST, skt_pkg::OP_LAST: begin
						cmd.cur_op = skt_pkg::CUR_CLR;
						if (sts.cnt_zero) begin
							cmd.res_status = skt_pkg::ST_EMPTY;
						end else begin
							cmd.res_set = 1'b0;
							cmd.rd_en   = 1'b1;
							cmd.ra_sel  = (sts.op == skt_pkg::OP_FIRST) ?
								skt_pkg::RA_ZERO : skt_pkg::RA_LAST;
							state_d     = S_READ_SET;
						end
					end
					skt_pkg::OP_NEXT: begin
						if (!sts.cur_valid) begin
							cmd.res_status = skt_pkg::ST_NOTFOUND;
						end else if (sts.cur_last) begin
							cmd.cur_op     = skt_pkg::CUR_CLR;
							cmd.res_status = skt_pkg::ST_TAIL;
						end else begin
							cmd.res_set = 1'b0;
							cmd.rd_en   = 1'b1;
							cmd.ra_sel  = skt_pkg::RA_CUR_INC;
							state_d     = S_READ_SET;
						end
					end
					skt_pkg::OP_PREV: begin
						if (!sts.cur_valid) begin
							cmd.res_status = skt_pkg::ST_NOTFOUND;
						end else if (sts.cur_first) begin
							cmd.cur_op     = skt_pkg::CUR_CLR;
							cmd.res_status = skt_pkg::ST_HEAD;
						end else begin
							cmd.res_set = 1'b0;
							cmd.rd_en   = 1'b1;
							cmd.ra_sel  = skt_pkg::RA_CUR_DEC;
							state_d     = S_READ_SET;
						end
					end
					skt_pkg::OP_UPDATE, skt_pkg::OP_DELETE: begin
						if (!sts.cur_valid) begin
							cmd.cur_op     = skt_pkg::CUR_CLR;
							cmd.res_status = (sts.op == skt_pkg::OP_UPDATE) ?
								skt_pkg::ST_BADUPD : skt_pkg::ST_BADDEL;
						end else begin
							cmd.res_set = 1'b0;
							cmd.rd_en   = 1'b1;
							cmd.ra_sel  = skt_pkg::RA_CUR;
							state_d     = S_CHECK;
						end
					end
					skt_pkg::OP_RESET: begin
						cmd.cnt_op        = skt_pkg::CNT_CLR;
						cmd.cur_op        = skt_pkg::CUR_CLR;
						cmd.res_ok        = 1'b1;
						cmd.res_cnt_start = 1'b1;
					end
					skt_pkg::OP_COUNT: begin
						cmd.res_ok = 1'b1;
					end
					default: begin
						cmd.res_status = skt_pkg::ST_NONE;
					end
				endcase
			end
			S_SCAN_INS: begin
				if (sts.cmp_eq) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = skt_pkg::ST_DUP;
					state_d        = S_DONE;
				end else if (sts.cmp_lt) begin
					cmd.pos_sel = skt_pkg::POS_IDX;
					state_d     = S_INS_CHK;
				end else if (sts.idx_last) begin
					cmd.pos_sel = skt_pkg::POS_COUNT;
					state_d     = S_INS_CHK;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.ra_sel = skt_pkg::RA_INC;
				end
			end
			S_INS_CHK: begin
				if (sts.cnt_full) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = skt_pkg::ST_FULL;
					state_d        = S_DONE;
				end else if (sts.pos_at_end) begin
					state_d = S_PLACE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.ra_sel = skt_pkg::RA_LAST;
					state_d    = S_SHIFT_UP;
				end
			end
			S_SHIFT_UP: begin
				cmd.wr_sel = skt_pkg::WR_SHIFT_UP;
				if (sts.idx_at_pos) begin
					state_d = S_PLACE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.ra_sel = skt_pkg::RA_DEC;
				end
			end
			S_PLACE: begin
				cmd.wr_sel  = skt_pkg::WR_NEW;
				cmd.cnt_op  = skt_pkg::CNT_INC;
				cmd.res_set = 1'b1;
				cmd.res_ok  = 1'b1;
				state_d     = S_DONE;
			end
			S_SCAN_GET: begin
				if (sts.cmp_eq) begin
					cmd.cur_op   = skt_pkg::CUR_SET;
					cmd.res_set  = 1'b1;
					cmd.res_ok   = 1'b1;
					cmd.res_data = 1'b1;
					state_d      = S_DONE;
				end else if (sts.cmp_lt || sts.idx_last) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = skt_pkg::ST_NOTFOUND;
					state_d        = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.ra_sel = skt_pkg::RA_INC;
				end
			end
			S_READ_SET: begin
				cmd.cur_op   = skt_pkg::CUR_SET;
				cmd.res_set  = 1'b1;
				cmd.res_ok   = 1'b1;
				cmd.res_data = 1'b1;
				state_d      = S_DONE;
			end
			S_CHECK: begin
				cmd.res_set = 1'b1;
				state_d     = S_DONE;
				if (!sts.cmp_eq) begin
					cmd.cur_op     = skt_pkg::CUR_CLR;
					cmd.res_status = (sts.op == skt_pkg::OP_UPDATE) ?
						skt_pkg::ST_BADUPD : skt_pkg::ST_BADDEL;
				end else if (sts.op == skt_pkg::OP_UPDATE) begin
					cmd.wr_sel = skt_pkg::WR_VALUE;
					cmd.res_ok = 1'b1;
				end else begin
					cmd.cur_op = skt_pkg::CUR_CLR;
					if (sts.cur_last) begin
						cmd.cnt_op = skt_pkg::CNT_DEC;
						cmd.res_ok = 1'b1;
					end else begin
						cmd.res_set = 1'b0;
						cmd.rd_en   = 1'b1;
						cmd.ra_sel  = skt_pkg::RA_CUR_INC;
						state_d     = S_SHIFT_DN;
					end
				end
			end
			S_SHIFT_DN: begin
				cmd.wr_sel = skt_pkg::WR_SHIFT_DN;
				if (sts.idx_last) begin
					cmd.cnt_op  = skt_pkg::CNT_DEC;
					cmd.res_set = 1'b1;
					cmd.res_ok  = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.ra_sel = skt_pkg::RA_INC;
				end
			end
			S_DONE: begin
				if (!out_valid || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

FILE: hdl/sorted_keyed_table_with_cursor.sv
// Top level of the sorted keyed table with cursor.
// An ordered map of up to CAPACITY unique keys held in ascending order in a simple dual-port
// memory, with one cursor. One operation is worked at a time; a finished transaction waits in
// the output register while the next one is taken. Insert scans the held entries, reading one
// entry per cycle up to the insert point, then moves each later entry up by one per cycle;
// get scans entries from the first until a match or a larger key, and delete moves each entry
// after the cursor down by one. The memory takes one read and one write per cycle.
// The key order register is written through the configuration port; the user must write it
// only while the block is idle, which the block itself does not enforce.
module sorted_keyed_table_with_cursor #(
	parameter int CAPACITY   = skt_pkg::CAPACITY_DEF,
	parameter int KEY_BITS   = skt_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = skt_pkg::VALUE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [3:0]                       op,
	input  logic [KEY_BITS-1:0]              key,
	input  logic [VALUE_BITS-1:0]            value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             ok,
	output logic [3:0]                       status,
	output logic [KEY_BITS-1:0]              found_key,
	output logic [VALUE_BITS-1:0]            found_value,
	output logic [skt_pkg::COUNT_PORT_W-1:0] entry_count
);
	skt_pkg::cmd_t cmd;
	skt_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	skt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	skt_datapath #(
		.CAPACITY   (CAPACITY),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.op          (op),
		.key         (key),
		.value       (value),
		.ok          (ok),
		.status      (status),
		.found_key   (found_key),
		.found_value (found_value),
		.entry_count (entry_count)
	);

endmodule

FILE: test/sorted_keyed_table_with_cursor_test.sv
// Self-checking testbench for the sorted keyed table with cursor: random handshakes and a table model.
module sorted_keyed_table_with_cursor_test;
	import skt_pkg::*;

	localparam int DEPTH = 16;
	localparam int SETTLE_CYCLES = 48;
	localparam int STALL_LIMIT = 6000;

	typedef struct {
		logic [3:0]  op;
		logic [31:0] key;
		logic [31:0] val;
	} table_op_t;

	typedef struct {
		logic        ok;
		logic [3:0]  status;
		logic [31:0] found_key;
		logic [31:0] found_value;
		logic [10:0] entry_count;
	} table_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [3:0]  op = OP_COUNT;
	logic [31:0] key = '0;
	logic [31:0] value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        ok;
	logic [3:0]  status;
	logic [31:0] found_key;
	logic [31:0] found_value;
	logic [10:0] entry_count;

	sorted_keyed_table_with_cursor dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .key(key), .value(value),
		.out_valid(out_valid), .out_ready(out_ready), .ok(ok), .status(status),
		.found_key(found_key), .found_value(found_value), .entry_count(entry_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	table_op_t     pending_ops[$];
	table_result_t expected_results[$];
	logic [31:0]   key_pool[24];
	int            mismatches = 0;

	// Model state of the table.
	logic [31:0] model_keys[DEPTH];
	logic [31:0] model_vals[DEPTH];
	int          model_held = 0;
	int          model_cursor = 0;
	bit          model_cursor_ok = 0;
	bit          model_signed = 0;

	function automatic int order_keys(logic [31:0] a, logic [31:0] b);
		if (model_signed) begin
			a[31] = ~a[31];
			b[31] = ~b[31];
		end
		if (a < b) return -1;
		if (a > b) return 1;
		return 0;
	endfunction

	task automatic predict_table_op(table_op_t t);
		table_result_t r;
		int i, n, c;
		bit hit, stop;
		r = '{1'b0, ST_NONE, 32'd0, 32'd0, 11'd0};
		n = model_held;
		if (model_cursor_ok && model_cursor >= n) model_cursor_ok = 0;
		r.entry_count = 11'(n);
		hit = 0;
		stop = 0;
		i = 0;
		if (t.op == OP_INSERT || t.op == OP_GET) begin
			model_cursor_ok = 0;
			while (i < n && !stop) begin
				c = order_keys(t.key, model_keys[i]);
				if (c == 0) begin
					hit = 1;
					stop = 1;
				end else if (c < 0) begin
					stop = 1;
				end else begin
					i++;
				end
			end
		end
		case (t.op)
			OP_INSERT: begin
				if (hit) r.status = ST_DUP;
				else if (n >= DEPTH) r.status = ST_FULL;
				else begin
					for (int j = n; j > i; j--) begin
						model_keys[j] = model_keys[j-1];
						model_vals[j] = model_vals[j-1];
					end
					model_keys[i] = t.key;
					model_vals[i] = t.val;
					model_held = n + 1;
					r.ok = 1;
					r.entry_count = 11'(model_held);
				end
			end
			OP_GET: begin
				if (hit) begin
					model_cursor = i;
					model_cursor_ok = 1;
				end else r.status = ST_NOTFOUND;
			end
			OP_FIRST, OP_LAST: begin
				model_cursor_ok = 0;
				if (n == 0) r.status = ST_EMPTY;
				else begin
					model_cursor = (t.op == OP_FIRST) ? 0 : n - 1;
					model_cursor_ok = 1;
					hit = 1;
				end
			end
			OP_NEXT, OP_PREV: begin
				if (!model_cursor_ok) r.status = ST_NOTFOUND;
				else if (t.op == OP_NEXT && model_cursor + 1 >= n) begin
					model_cursor_ok = 0;
					r.status = ST_TAIL;
				end else if (t.op == OP_PREV && model_cursor == 0) begin
					model_cursor_ok = 0;
					r.status = ST_HEAD;
				end else begin
					model_cursor = (t.op == OP_NEXT) ? model_cursor + 1 : model_cursor - 1;
					hit = 1;
				end
			end
			OP_UPDATE, OP_DELETE: begin
				if (!model_cursor_ok || model_keys[model_cursor] != t.key) begin
					model_cursor_ok = 0;
					r.status = (t.op == OP_UPDATE) ? ST_BADUPD : ST_BADDEL;
				end else begin
					if (t.op == OP_UPDATE) model_vals[model_cursor] = t.val;
					else begin
						for (int j = model_cursor; j < n - 1; j++) begin
							model_keys[j] = model_keys[j+1];
							model_vals[j] = model_vals[j+1];
						end
						model_held = n - 1;
						model_cursor_ok = 0;
					end
					r.ok = 1;
					r.entry_count = 11'(model_held);
				end
			end
			OP_RESET: begin
				model_held = 0;
				model_cursor = 0;
				model_cursor_ok = 0;
				r.ok = 1;
			end
			OP_COUNT: r.ok = 1;
			default: ;
		endcase
		if (hit && t.op != OP_INSERT) begin
			r.ok = 1;
			r.found_key = model_keys[model_cursor];
			r.found_value = model_vals[model_cursor];
		end
		expected_results.push_back(r);
	endtask

	task automatic queue_op(logic [3:0] o, logic [31:0] k, logic [31:0] v);
		pending_ops.push_back('{o, k, v});
	endtask

	function automatic logic [31:0] pool_key();
		return key_pool[$urandom_range(0, 23)];
	endfunction

	task automatic queue_random_phase(int count);
		logic [31:0] k;
		int steps;
		while (count > 0) begin
			k = pool_key();
			case ($urandom_range(0, 15))
				0, 1, 2, 3: begin
					queue_op(OP_INSERT, k, $urandom);
					count -= 1;
				end
				4, 5: begin
					queue_op(OP_GET, k, $urandom);
					queue_op(OP_UPDATE, ($urandom_range(0, 7) == 0) ? pool_key() : k, $urandom);
					count -= 2;
				end
				6, 7: begin
					queue_op(OP_GET, k, $urandom);
					queue_op(OP_DELETE, ($urandom_range(0, 7) == 0) ? pool_key() : k, $urandom);
					count -= 2;
				end
				8, 9: begin
					steps = $urandom_range(1, 18);
					queue_op($urandom_range(0, 1) ? OP_FIRST : OP_LAST, $urandom, $urandom);
					repeat (steps) queue_op($urandom_range(0, 3) ? OP_NEXT : OP_PREV,
						$urandom, $urandom);
					count -= steps + 1;
				end
				10: begin
					queue_op(OP_GET, k, $urandom);
					queue_op(4'($urandom_range(OP_NEXT, OP_PREV)), $urandom, $urandom);
					count -= 2;
				end
				11: begin
					queue_op(OP_COUNT, $urandom, $urandom);
					count -= 1;
				end
				12: begin
					if ($urandom_range(0, 5) == 0) queue_op(OP_RESET, $urandom, $urandom);
					else queue_op(OP_INSERT, $urandom, $urandom);
					count -= 1;
				end
				default: begin
					queue_op(4'($urandom_range(0, 15)), $urandom, $urandom);
					count -= 1;
				end
			endcase
		end
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_key_order(logic setting);
		cfg_valid <= 1'b1;
		cfg_data <= setting;
		@(posedge clk);
		while (!(cfg_valid && cfg_ready)) @(posedge clk);
		model_signed = setting;
		cfg_valid <= 1'b0;
	endtask

	// Stimulus: directed part, then phases under alternating key order.
	initial begin
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		key_pool[2] = 32'h8000_0000;
		key_pool[3] = 32'h7FFF_FFFF;
		for (int i = 4; i < 24; i++) key_pool[i] = $urandom;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_key_order(1'b0);
		queue_op(OP_COUNT, 32'h0, 32'h0);
		queue_op(OP_FIRST, 32'h0, 32'h0);
		queue_op(OP_LAST, 32'h0, 32'h0);
		queue_op(OP_GET, 32'h0, 32'h0);
		queue_op(OP_NEXT, 32'h0, 32'h0);
		queue_op(OP_UPDATE, 32'h0, 32'h1);
		queue_op(OP_DELETE, 32'h0, 32'h1);
		queue_op(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_op(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
		queue_op(OP_INSERT, 32'h8000_0000, 32'h5555_5555);
		queue_op(OP_INSERT, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
		queue_op(OP_INSERT, 32'h8000_0000, 32'h1234_5678);
		queue_op(OP_FIRST, 32'h0, 32'h0);
		queue_op(OP_PREV, 32'h0, 32'h0);
		queue_op(OP_LAST, 32'h0, 32'h0);
		queue_op(OP_NEXT, 32'h0, 32'h0);
		queue_op(OP_GET, 32'h8000_0000, 32'h0);
		queue_op(OP_UPDATE, 32'h7FFF_FFFF, 32'h0);
		queue_op(OP_GET, 32'h8000_0000, 32'h0);
		queue_op(OP_UPDATE, 32'h8000_0000, 32'hFFFF_FFFF);
		queue_op(OP_DELETE, 32'h0000_0001, 32'h0);
		queue_op(OP_GET, 32'h7FFF_FFFF, 32'h0);
		queue_op(OP_DELETE, 32'h7FFF_FFFF, 32'h0);
		queue_op(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_op(OP_RESET, 32'h0, 32'h0);
		queue_random_phase(250);
		wait_idle();
		write_key_order(1'b1);
		queue_random_phase(260);
		wait_idle();
		write_key_order(1'b0);
		queue_random_phase(260);
		wait_idle();
		write_key_order(1'b1);
		queue_random_phase(260);
		wait_idle();
		if (mismatches == 0 && expected_results.size() == 0)
			$display("sorted_keyed_table_with_cursor_test: PASS");
		else
			$display("sorted_keyed_table_with_cursor_test: FAIL");
		$finish;
	end

	// Sender: one operation per transaction with a random gap between operations.
	int send_gap = 0;
	always @(posedge clk) begin
		bit busy;
		table_op_t t;
		busy = in_valid;
		if (in_valid && in_ready) begin
			predict_table_op('{op, key, value});
			busy = 0;
		end
		if (!busy && arst_n) begin
			if (send_gap > 0) send_gap--;
			else if (pending_ops.size() != 0) begin
				t = pending_ops.pop_front();
				op <= t.op;
				key <= t.key;
				value <= t.val;
				busy = 1;
				send_gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
			end
		end
		in_valid <= busy;
	end

	// Receiver: checks each transaction, stalls at random, and holds off once for a long stretch.
	int recv_stall = 0;
	int hold_left = 0;
	int results_seen = 0;
	bit held_once = 0;
	always @(posedge clk) begin
		table_result_t e;
		if (out_valid && out_ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result ok=%0d status=%0d", ok, status);
			end else begin
				e = expected_results.pop_front();
				if (ok !== e.ok || status !== e.status || found_key !== e.found_key ||
					found_value !== e.found_value || entry_count !== e.entry_count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp ok=%0d st=%0d k=%h v=%h n=%0d, got ok=%0d st=%0d k=%h v=%h n=%0d",
							e.ok, e.status, e.found_key, e.found_value, e.entry_count,
							ok, status, found_key, found_value, entry_count);
				end
			end
			recv_stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (results_seen == 150 && !held_once) begin
			held_once = 1;
			hold_left = 400;
			out_ready <= 1'b0;
		end else if (recv_stall > 0) begin
			recv_stall--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n;
		end
	end

	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles + 1 >= STALL_LIMIT) begin
			$display("sorted_keyed_table_with_cursor_test: FAIL");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

endmodule
